// File: rtl/ssd_pkg.sv
// Shared types and constants of the seismometer sample decoder.
package ssd_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH_ENABLE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LEVEL       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH     = 3'd4;

    localparam logic [15:0] THRESHOLD_RESET = 16'd500;
    localparam logic [10:0] BLOCK_LENGTH_RESET = 11'd1;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_VT    = 8'h0b;
    localparam logic [7:0] CHAR_FF    = 8'h0c;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    typedef enum logic [3:0] {
        PH_LEAD   = 4'b0001,
        PH_DIGITS = 4'b0010,
        PH_ENDED  = 4'b0100,
        PH_NUL    = 4'b1000
    } ssd_phase_t;

    typedef struct packed {
        logic load_byte;
        logic commit;
        logic div_start;
        logic div_step;
        logic load_div_out;
    } ssd_cmd_t;

    typedef struct packed {
        logic emits;
        logic block_end;
        logic div_last;
        logic out_blocked;
    } ssd_status_t;

endpackage

// File: rtl/ssd_ctrl.sv
// Controller state machine that sequences byte processing and block division.
module ssd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ssd_pkg::ssd_status_t status,
    output ssd_pkg::ssd_cmd_t    cmd
);
    import ssd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PROC = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } ssd_state_t;

    ssd_state_t state_reg;
    ssd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_byte = 1'b1;
                    state_next = S_PROC;
                end
            end
            S_PROC:
            begin
                if (status.block_end)
                begin
                    cmd.commit = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
                else if (!(status.emits && status.out_blocked))
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!status.out_blocked)
                begin
                    cmd.load_div_out = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/ssd_datapath.sv
// Datapath: configuration, line parser, binary framer, block divider and output register.
module ssd_datapath #(
    parameter int MAX_LINE  = 20,
    parameter int MAX_BLOCK = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ssd_pkg::ssd_cmd_t                cmd,
    output ssd_pkg::ssd_status_t             status,
    input  logic [7:0]                       rx_byte,
    input  logic                             cfg_we,
    input  logic [ssd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ssd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [15:0]               sample,
    output logic                             glitch_replaced
);
    import ssd_pkg::*;

    localparam int LEN_W = $clog2(MAX_LINE + 2);
    localparam int BL_W  = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W = $clog2(MAX_BLOCK) + 12;
    localparam int DVD_W = SUM_W + 4;
    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam int TOT_W = DVD_W + 2;

    logic             mode_reg;
    logic             glitch_en_reg;
    logic [15:0]      threshold_reg;
    logic [15:0]      zero_reg;
    logic [10:0]      block_len_reg;

    logic [7:0]       byte_reg;
    logic [LEN_W-1:0] line_len_reg, line_len_next;
    logic [15:0]      acc_reg, acc_next;
    logic             neg_reg, neg_next;
    ssd_phase_t       phase_reg, phase_next;
    logic [15:0]      last_reg, last_next;
    logic [7:0]       low_reg, low_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [BL_W-1:0]  left_reg, left_next;

    logic [BL_W-1:0]  rem_reg;
    logic [DVD_W-1:0] quot_reg;
    logic [BL_W-1:0]  den_reg;
    logic [CNT_W-1:0] count_reg;

    logic             out_valid_reg;
    logic [15:0]      out_sample_reg;
    logic             out_glitch_reg;

    logic             emits;
    logic             block_end;
    logic [15:0]      ascii_value;
    logic             ascii_replaced;
    logic [SUM_W-1:0] sum_new;
    logic [31:0]      eff_wide;
    logic [BL_W-1:0]  eff_len;
    logic [BL_W:0]    div_trial;
    logic             div_bit;
    logic [TOT_W-1:0] total;
    logic [15:0]      div_sample;
    logic             load_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            glitch_en_reg <= 1'b0;
            threshold_reg <= THRESHOLD_RESET;
            zero_reg      <= 16'd0;
            block_len_reg <= BLOCK_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INPUT_MODE:       mode_reg      <= cfg_data[0];
                CFG_GLITCH_ENABLE:    glitch_en_reg <= cfg_data[0];
                CFG_GLITCH_THRESHOLD: threshold_reg <= cfg_data;
                CFG_ZERO_LEVEL:       zero_reg      <= cfg_data;
                CFG_BLOCK_LENGTH:     block_len_reg <= cfg_data[10:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_byte)
        begin
            byte_reg <= rx_byte;
        end
    end

    always_comb
    begin
        eff_wide = 32'(block_len_reg);
        if (eff_wide < 32'd1)
        begin
            eff_wide = 32'd1;
        end
        if (eff_wide > 32'(MAX_BLOCK))
        begin
            eff_wide = 32'(MAX_BLOCK);
        end
        eff_len = eff_wide[BL_W-1:0];
    end

    always_comb
    begin
        logic        over;
        logic        empty;
        logic        blank;
        logic        digit;
        logic [15:0] acc10;
        logic [15:0] v;
        logic [16:0] d;
        logic [16:0] ad;

        line_len_next = line_len_reg;
        acc_next = acc_reg;
        neg_next = neg_reg;
        phase_next = phase_reg;
        last_next = last_reg;
        low_next = low_reg;
        sum_next = sum_reg;
        left_next = left_reg;
        emits = 1'b0;
        block_end = 1'b0;
        ascii_replaced = 1'b0;
        sum_new = sum_reg + SUM_W'({byte_reg[7:1], low_reg[7:3]});

        over = line_len_reg > LEN_W'(MAX_LINE);
        empty = (line_len_reg == '0) || (phase_reg == PH_NUL);
        blank = (byte_reg == CHAR_SPACE) || (byte_reg == CHAR_TAB) ||
                (byte_reg == CHAR_VT) || (byte_reg == CHAR_FF);
        digit = (byte_reg >= CHAR_ZERO) && (byte_reg <= CHAR_NINE);
        acc10 = {acc_reg[12:0], 3'b000} + {acc_reg[14:0], 1'b0} + {12'd0, byte_reg[3:0]};
        v = neg_reg ? (16'd0 - acc_reg) : acc_reg;
        d = {last_reg[15], last_reg} - {v[15], v};
        ad = d[16] ? (17'd0 - d) : d;
        ascii_value = v;

        if (!mode_reg)
        begin
            if (over || (byte_reg == CHAR_LF) || (byte_reg == CHAR_CR))
            begin
                line_len_next = '0;
                acc_next = 16'd0;
                neg_next = 1'b0;
                phase_next = PH_LEAD;
                if (!over && (byte_reg == CHAR_CR) && !empty)
                begin
                    emits = 1'b1;
                    if (glitch_en_reg && (last_reg != 16'd0) && (ad > {1'b0, threshold_reg}))
                    begin
                        ascii_value = last_reg;
                        ascii_replaced = 1'b1;
                    end
                    else
                    begin
                        last_next = v;
                    end
                end
            end
            else
            begin
                line_len_next = line_len_reg + LEN_W'(1);
                if (byte_reg == CHAR_NUL)
                begin
                    if ((line_len_reg == '0) || (phase_reg == PH_NUL))
                    begin
                        phase_next = PH_NUL;
                    end
                    else
                    begin
                        phase_next = PH_ENDED;
                    end
                end
                else
                begin
                    case (phase_reg)
                        PH_LEAD:
                        begin
                            if (blank)
                            begin
                                phase_next = PH_LEAD;
                            end
                            else if ((byte_reg == CHAR_PLUS) || (byte_reg == CHAR_MINUS))
                            begin
                                neg_next = (byte_reg == CHAR_MINUS);
                                phase_next = PH_DIGITS;
                            end
                            else if (digit)
                            begin
                                acc_next = acc10;
                                phase_next = PH_DIGITS;
                            end
                            else
                            begin
                                phase_next = PH_ENDED;
                            end
                        end
                        PH_DIGITS:
                        begin
                            if (digit)
                            begin
                                acc_next = acc10;
                            end
                            else
                            begin
                                phase_next = PH_ENDED;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
        end
        else
        begin
            if (line_len_reg > LEN_W'(2))
            begin
                line_len_next = '0;
            end
            else if (!byte_reg[0])
            begin
                low_next = byte_reg;
            end
            else
            begin
                line_len_next = '0;
                if (left_reg > BL_W'(1))
                begin
                    sum_next = sum_new;
                    left_next = left_reg - BL_W'(1);
                end
                else
                begin
                    block_end = 1'b1;
                    sum_next = '0;
                    left_next = eff_len;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_len_reg <= '0;
            acc_reg <= 16'd0;
            neg_reg <= 1'b0;
            phase_reg <= PH_LEAD;
            last_reg <= 16'd0;
            low_reg <= 8'd0;
            sum_reg <= '0;
            left_reg <= BL_W'(1);
        end
        else if (cmd.commit)
        begin
            line_len_reg <= line_len_next;
            acc_reg <= acc_next;
            neg_reg <= neg_next;
            phase_reg <= phase_next;
            last_reg <= last_next;
            low_reg <= low_next;
            sum_reg <= sum_next;
            left_reg <= left_next;
        end
    end

    assign div_trial = {rem_reg, quot_reg[DVD_W-1]};
    assign div_bit = div_trial >= {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quot_reg <= {sum_new, 4'b0000};
            den_reg <= eff_len;
            count_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_bit ? BL_W'(div_trial - {1'b0, den_reg}) : div_trial[BL_W-1:0];
            quot_reg <= {quot_reg[DVD_W-2:0], div_bit};
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        total = {2'b00, quot_reg} - {{(TOT_W-16){zero_reg[15]}}, zero_reg};
        if ($signed(total) > $signed(TOT_W'(SAMPLE_MAX)))
        begin
            div_sample = 16'(SAMPLE_MAX);
        end
        else if ($signed(total) < $signed(TOT_W'(SAMPLE_MIN)))
        begin
            div_sample = 16'(SAMPLE_MIN);
        end
        else
        begin
            div_sample = total[15:0];
        end
    end

    assign load_out = (cmd.commit && emits) || cmd.load_div_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_div_out)
        begin
            out_sample_reg <= div_sample;
            out_glitch_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_sample_reg <= ascii_value - zero_reg;
            out_glitch_reg <= ascii_replaced;
        end
    end

    assign status.emits = emits;
    assign status.block_end = block_end;
    assign status.div_last = count_reg == CNT_W'(DVD_W - 1);
    assign status.out_blocked = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign sample = $signed(out_sample_reg);
    assign glitch_replaced = out_glitch_reg;

endmodule

// File: rtl/seismometer_sample_decoder_core.sv
// Top level of the seismometer sample decoder: controller, datapath and checks.
//
//  channel | signals                          | direction
//  input   | in_valid, in_ready, rx_byte      | byte in
//  output  | out_valid, out_ready, sample,    | result out
//          | glitch_replaced                  |
//  config  | cfg_valid, cfg_ready, cfg_index, | register write in
//          | cfg_data                         |
//
// Each byte is taken in the idle state and then handled in the processing state.
// A binary byte that closes a block then passes to the restoring divider, which
// forms one quotient bit a cycle; its result then waits until the output is free.
// Reset clears all control and parser state at once; there is no clearing pass.
// A result waits in the output register while the next byte is taken; a byte
// that yields a result holds in processing until that register is free.
module seismometer_sample_decoder_core #(
    parameter int MAX_LINE  = 20,
    parameter int MAX_BLOCK = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       rx_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [15:0]               sample,
    output logic                             glitch_replaced,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ssd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ssd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ssd_pkg::*;

    ssd_cmd_t    cmd;
    ssd_status_t status;

    assign cfg_ready = 1'b1;

    ssd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ssd_datapath #(
        .MAX_LINE  (MAX_LINE),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .rx_byte         (rx_byte),
        .cfg_we          (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .sample          (sample),
        .glitch_replaced (glitch_replaced)
    );

`ifndef SYNTHESIS
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("Input was ready in the cycle after a transfer.");

    a_out_free_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_div_out |-> !(out_valid && !out_ready))
        else $error("Block result loaded over a pending result.");

    a_div_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (cmd.div_step && !in_ready))
        else $error("Division did not begin after block end.");
`endif

endmodule
